/* design/rsg_pkg.sv */
// rsg_pkg: shared types and constants for the random stereo gate.
// Used by rsg_ctrl, rsg_dp and random_stereo_gate; depends on nothing.
`default_nettype none

package rsg_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [31:0] LCG_MUL   = 32'd1664525;
    localparam logic [31:0] LCG_ADD   = 32'd1013904223;
    localparam logic [16:0] UNITY_Q16 = 17'd65536;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AMOUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED       = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
        logic                          last_frame;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          last_out;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic cap;      // capture input transaction
        logic draw;     // window count, advance generator
        logic tgt;      // compare draw, set gain target
        logic gain;     // step gain toward target
        logic wet;      // gain * mix
        logic mul;      // sample * wet
        logic ld_out;   // saturate into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* design/rsg_ctrl.sv */
// rsg_ctrl: sequencer for one frame through the gate datapath.
// Depends on rsg_pkg (t_cmd, t_sts).
`default_nettype none

module rsg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rsg_pkg::t_sts i_sts,
    output rsg_pkg::t_cmd o_cmd
);
    import rsg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DRAW = 3'd1;
    localparam logic [2:0] S_TGT  = 3'd2;
    localparam logic [2:0] S_GAIN = 3'd3;
    localparam logic [2:0] S_WET  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = o_in_ready && i_in_valid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.cap    = w_acc;
        o_cmd.draw   = (r_state == S_DRAW);
        o_cmd.tgt    = (r_state == S_TGT);
        o_cmd.gain   = (r_state == S_GAIN);
        o_cmd.wet    = (r_state == S_WET);
        o_cmd.mul    = (r_state == S_MUL);
        o_cmd.ld_out = (r_state == S_OUT) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc) n_state = S_DRAW;
            S_DRAW: n_state = S_TGT;
            S_TGT:  n_state = S_GAIN;
            S_GAIN: n_state = S_WET;
            S_WET:  n_state = S_MUL;
            S_MUL:  n_state = S_OUT;
            S_OUT:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_out |-> i_sts.out_free)
        else $error("output load while output register full");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == S_DRAW))
        else $error("accepted frame did not start the sequence");

    a_out_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_sts.out_free) |=> (r_state == S_OUT))
        else $error("left output step without loading the result");

endmodule

`default_nettype wire

/* design/rsg_dp.sv */
// rsg_dp: configuration registers, generator, gain fade, wet factor,
// sample scaling and output register. Depends on rsg_pkg.
`default_nettype none

module rsg_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rsg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rsg_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  rsg_pkg::t_cmd                      i_cmd,
    output rsg_pkg::t_sts                      o_sts,
    input  rsg_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output rsg_pkg::t_out_item                 o_out_data
);
    import rsg_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int PW = SB + 18;   // sample times signed-extended Q16 wet
    localparam int QW = PW - 16;   // product after the Q16 floor shift

    // configuration
    logic [24:0] r_amount;
    logic [16:0] r_mix;
    logic [15:0] r_win;
    logic [16:0] r_fstep;

    // state
    logic [31:0] r_rng;
    logic [16:0] r_gain;
    logic        r_target;
    logic [15:0] r_frames;
    logic        r_drew;

    // per-frame payload
    logic signed [SB-1:0] r_l;
    logic signed [SB-1:0] r_r;
    logic                 r_last;
    logic [16:0]          r_wet;
    logic signed [PW-1:0] r_pl;
    logic signed [PW-1:0] r_pr;

    t_out_item r_out;
    logic      r_ovalid;

    logic [31:0] w_rng_next;
    logic [16:0] w_tgt;
    logic [17:0] w_sum;
    logic [16:0] w_diff;
    logic [16:0] w_gain_next;
    logic [16:0] w_mix_c;
    logic [33:0] w_gm;
    logic [16:0] w_wet;

    function automatic logic signed [SB-1:0] sat(input logic signed [QW-1:0] q);
        logic signed [SB-1:0] hi;
        logic signed [SB-1:0] lo;
        hi = {1'b0, {(SB-1){1'b1}}};
        lo = {1'b1, {(SB-1){1'b0}}};
        // in range when the guard bits all match the sign
        if (q[QW-1:SB-1] == '0 || q[QW-1:SB-1] == '1) begin
            sat = q[SB-1:0];
        end else if (q[QW-1]) begin
            sat = lo;
        end else begin
            sat = hi;
        end
    endfunction

    assign w_rng_next = r_rng * LCG_MUL + LCG_ADD;
    assign w_tgt      = r_target ? UNITY_Q16 : 17'd0;
    assign w_sum      = {1'b0, r_gain} + {1'b0, r_fstep};
    assign w_diff     = r_gain - w_tgt;

    always_comb begin
        w_gain_next = r_gain;
        if (r_gain < w_tgt) begin
            w_gain_next = (w_sum > {1'b0, w_tgt}) ? w_tgt : w_sum[16:0];
        end else if (r_gain > w_tgt) begin
            w_gain_next = (w_diff > r_fstep) ? (r_gain - r_fstep) : w_tgt;
        end
    end

    assign w_mix_c = (r_mix > UNITY_Q16) ? UNITY_Q16 : r_mix;
    assign w_gm    = r_gain * w_mix_c;
    assign w_wet   = w_gm[32:16] + (UNITY_Q16 - w_mix_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amount <= 25'd8388608;
            r_mix    <= UNITY_Q16;
            r_win    <= 16'd2400;
            r_fstep  <= 17'd273;
            r_rng    <= 32'd1;
            r_gain   <= UNITY_Q16;
            r_target <= 1'b1;
            r_frames <= 16'd0;
            r_drew   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_AMOUNT:     r_amount <= i_cfg_wdata[24:0];
                    REG_MIX_LEVEL:  r_mix    <= i_cfg_wdata[16:0];
                    REG_WINDOW_LEN: r_win    <= i_cfg_wdata[15:0];
                    REG_FADE_STEP:  r_fstep  <= i_cfg_wdata[16:0];
                    REG_SEED:       r_rng    <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.draw) begin
                if (r_frames == 16'd0) begin
                    // window start; a zero length acts as one
                    r_rng    <= w_rng_next;
                    r_frames <= (r_win == 16'd0) ? 16'd0 : r_win - 16'd1;
                    r_drew   <= 1'b1;
                end else begin
                    r_frames <= r_frames - 16'd1;
                    r_drew   <= 1'b0;
                end
            end
            if (i_cmd.tgt && r_drew) begin
                r_target <= !({1'b0, r_rng[31:8]} < r_amount);
            end
            if (i_cmd.gain) begin
                r_gain <= w_gain_next;
            end
            if (i_cmd.ld_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_l    <= i_in_data.left_in;
            r_r    <= i_in_data.right_in;
            r_last <= i_in_data.last_frame;
        end
        if (i_cmd.wet) begin
            r_wet <= w_wet;
        end
        if (i_cmd.mul) begin
            r_pl <= r_l * $signed({1'b0, r_wet});
            r_pr <= r_r * $signed({1'b0, r_wet});
        end
        if (i_cmd.ld_out) begin
            // arithmetic shift gives floor division by 2^16
            r_out.left_out  <= sat(r_pl[PW-1:16]);
            r_out.right_out <= sat(r_pr[PW-1:16]);
            r_out.last_out  <= r_last;
        end
    end

    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_out_data     = r_out;

    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= UNITY_Q16)
        else $error("gain above unity");

    a_wet_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wet |=> r_wet <= UNITY_Q16)
        else $error("wet factor above unity");

    a_frames_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.draw && r_frames == 16'd0 && !i_cfg_we) |=> r_drew)
        else $error("window start without a draw");

endmodule

`default_nettype wire

/* design/random_stereo_gate.sv */
// random_stereo_gate: top level, controller plus datapath.
// Depends on rsg_pkg, rsg_ctrl, rsg_dp.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------
//  input    | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  output   | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//  config   | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_wdata
//
// An accepted frame is taken through generator multiply, draw compare, gain step,
// gain*mix, sample*wet and saturation into the output register, one sequencer
// step each; input is ready again in the cycle after the result is loaded. A
// full, stalled output register holds the sequencer in its last step, so input
// stalls follow. Synchronous active-low reset restores register reset values
// and opens the gate at unity gain.
`default_nettype none

module random_stereo_gate (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  rsg_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output rsg_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_we,
    input  logic [rsg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rsg_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import rsg_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    rsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rsg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* sim/testbench.sv */
// testbench: self-checking bench for random_stereo_gate (directed table, then random phases).
// Needs rsg_pkg and the random_stereo_gate RTL. Results are checked against an in-bench
// predictor of the generator, gain fade and wet scaling.
`timescale 1ns / 100ps

module testbench;
    import rsg_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int DRAIN_PAD       = 10;

    typedef struct {
        bit                     is_cfg;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  wdata;
        t_in_item               frame;
        bit                     typed;
        t_out_item              want;
    } t_plan_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_in_item               i_in_data;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_out_item              o_out_data;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;

    // predictor state and register copies
    logic [24:0] amount_cfg;
    logic [16:0] mix_cfg;
    logic [15:0] window_cfg;
    logic [16:0] fade_cfg;
    logic [31:0] rng_word;
    logic [16:0] gain_q16;
    logic        gate_open;
    logic [15:0] frames_to_draw;

    t_out_item   pending_frames[$];
    t_plan_row   plan[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          stall_left  = 0;
    bit          idle_on     = 1'b1;

    random_stereo_gate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic signed [SAMPLE_BITS-1:0] scale_sample(
        input logic signed [SAMPLE_BITS-1:0] s, input longint unsigned wet);
        longint q;
        q = (longint'(s) * longint'(wet)) >>> 16;   // floor
        if (q > 64'sd8388607)
            q = 64'sd8388607;
        else if (q < -64'sd8388608)
            q = -64'sd8388608;
        return q[SAMPLE_BITS-1:0];
    endfunction

    function automatic t_out_item gate_frame(input t_in_item f);
        int unsigned       level;
        int unsigned       tgt;
        int unsigned       mix_eff;
        longint unsigned   wet;
        t_out_item         r;
        if (frames_to_draw == 16'd0) begin
            rng_word       = rng_word * LCG_MUL + LCG_ADD;
            gate_open      = (rng_word[31:8] >= amount_cfg);
            frames_to_draw = (window_cfg == 16'd0) ? 16'd1 : window_cfg;
        end
        frames_to_draw = frames_to_draw - 16'd1;

        tgt   = gate_open ? UNITY_Q16 : 0;
        level = gain_q16;
        if (level < tgt) begin
            level = level + fade_cfg;
            if (level > tgt)
                level = tgt;
        end else if (level > tgt) begin
            level = (level - tgt > fade_cfg) ? level - fade_cfg : tgt;
        end
        gain_q16 = level[16:0];

        mix_eff = (mix_cfg > UNITY_Q16) ? UNITY_Q16 : mix_cfg;
        wet     = level;
        wet     = ((wet * mix_eff) >> 16) + (UNITY_Q16 - mix_eff);

        r.left_out  = scale_sample(f.left_in, wet);
        r.right_out = scale_sample(f.right_in, wet);
        r.last_out  = f.last_frame;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_plan_row row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.wdata  = data;
        return row;
    endfunction

    function automatic t_plan_row frame_row(input int l, input int r, input bit last,
                                            input bit typed = 1'b0, input int wl = 0,
                                            input int wr = 0, input bit wlast = 1'b0);
        t_plan_row row;
        row                  = '{default: '0};
        row.frame.left_in    = l[SAMPLE_BITS-1:0];
        row.frame.right_in   = r[SAMPLE_BITS-1:0];
        row.frame.last_frame = last;
        row.typed            = typed;
        row.want.left_out    = wl[SAMPLE_BITS-1:0];
        row.want.right_out   = wr[SAMPLE_BITS-1:0];
        row.want.last_out    = wlast;
        return row;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        int v;
        case ($urandom_range(0, 7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: begin
                v = int'($urandom_range(0, 600)) - 300;
                return v[SAMPLE_BITS-1:0];
            end
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_AMOUNT:     amount_cfg = data[24:0];
            REG_MIX_LEVEL:  mix_cfg    = data[16:0];
            REG_WINDOW_LEN: window_cfg = data[15:0];
            REG_FADE_STEP:  fade_cfg   = data[16:0];
            REG_SEED:       rng_word   = data;     // window count is not restarted
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // wait until every frame in flight has come back
    task automatic drain_wait();
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic send_frame(input t_in_item f, input bit typed, input t_out_item want);
        t_out_item predicted;
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = gate_frame(f);
        pending_frames.push_back(typed ? want : predicted);
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // output side: random stall bursts
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(0, 12);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_frames.size() == 0) begin
                $error("result transaction with no frame outstanding");
                error_count++;
            end else begin
                want = pending_frames.pop_front();
                if (o_out_data.left_out !== want.left_out) begin
                    $error("left_out: expected %0d, got %0d", want.left_out,
                           o_out_data.left_out);
                    error_count++;
                end
                if (o_out_data.right_out !== want.right_out) begin
                    $error("right_out: expected %0d, got %0d", want.right_out,
                           o_out_data.right_out);
                    error_count++;
                end
                if (o_out_data.last_out !== want.last_out) begin
                    $error("last_out: expected %0d, got %0d", want.last_out,
                           o_out_data.last_out);
                    error_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("random_stereo_gate test failed");
        $finish;
    end

    initial begin
        t_in_item f;
        int       seed_at;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= REG_AMOUNT;
        i_cfg_wdata <= '0;

        amount_cfg     = 25'd8388608;
        mix_cfg        = UNITY_Q16;
        window_cfg     = 16'd2400;
        fade_cfg       = 17'd273;
        rng_word       = 32'd1;
        gain_q16       = UNITY_Q16;
        gate_open      = 1'b1;
        frames_to_draw = 16'd0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero window: a draw every frame until the window length changes
        plan.push_back(cfg_row(REG_WINDOW_LEN, 0));
        plan.push_back(frame_row(8388607, -8388608, 1));
        // no mix: samples pass straight through
        plan.push_back(cfg_row(REG_MIX_LEVEL, 0));
        plan.push_back(frame_row(8388607, -8388608, 1, 1, 8388607, -8388608, 1));
        plan.push_back(frame_row(-1, 0, 0, 1, -1, 0, 0));
        plan.push_back(frame_row(1, -1, 1, 1, 1, -1, 1));
        // mix above unity, amount above one, step past the target: silence
        plan.push_back(cfg_row(REG_MIX_LEVEL, 131071));
        plan.push_back(cfg_row(REG_AMOUNT, 33554431));
        plan.push_back(cfg_row(REG_FADE_STEP, 131071));
        plan.push_back(frame_row(8388607, -8388608, 0, 1, 0, 0, 0));
        plan.push_back(frame_row(-1, -1, 1, 1, 0, 0, 1));
        // gate opens but a zero step keeps gain frozen at zero
        plan.push_back(cfg_row(REG_AMOUNT, 0));
        plan.push_back(cfg_row(REG_FADE_STEP, 0));
        plan.push_back(frame_row(-8388608, 8388607, 1, 1, 0, 0, 1));
        plan.push_back(frame_row(-5, 5, 0, 1, 0, 0, 0));
        plan.push_back(cfg_row(REG_FADE_STEP, 1));
        plan.push_back(frame_row(8388607, -8388608, 0));
        // full step clamps to unity
        plan.push_back(cfg_row(REG_FADE_STEP, 65536));
        plan.push_back(frame_row(8388607, -8388608, 1, 1, 8388607, -8388608, 1));
        plan.push_back(frame_row(-1, 1, 0, 1, -1, 1, 0));
        // amount exactly one, half mix, short windows, seed loads mid window
        plan.push_back(cfg_row(REG_AMOUNT, 16777216));
        plan.push_back(cfg_row(REG_MIX_LEVEL, 32768));
        plan.push_back(cfg_row(REG_FADE_STEP, 273));
        plan.push_back(cfg_row(REG_WINDOW_LEN, 3));
        plan.push_back(frame_row(-1, 1, 0));
        plan.push_back(frame_row(-8388608, 8388607, 1));
        plan.push_back(cfg_row(REG_SEED, 0));
        plan.push_back(frame_row(100, -100, 1));
        plan.push_back(frame_row(-3, 3, 0));
        plan.push_back(cfg_row(REG_SEED, 32'hFFFF_FFFF));
        plan.push_back(frame_row(4096, -4096, 0));
        plan.push_back(frame_row(8388607, -8388608, 1));

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                drain_wait();
                cfg_write(plan[k].idx, plan[k].wdata);
            end else begin
                sender_gap();
                send_frame(plan[k].frame, plan[k].typed, plan[k].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_wait();
            idle_on = (phase < PHASES - 3) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0: cfg_write(REG_AMOUNT, 0);
                    1: cfg_write(REG_AMOUNT, 16777216);
                    2: cfg_write(REG_AMOUNT, 33554431);
                    default: cfg_write(REG_AMOUNT, $urandom_range(0, 16777216));
                endcase
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0: cfg_write(REG_MIX_LEVEL, 0);
                    1: cfg_write(REG_MIX_LEVEL, 65536);
                    2: cfg_write(REG_MIX_LEVEL, 131071);
                    default: cfg_write(REG_MIX_LEVEL, $urandom_range(0, 65536));
                endcase
            end
            // long windows stall the draws, so the widest one goes last
            if (phase == PHASES - 1)
                cfg_write(REG_WINDOW_LEN, 65535);
            else if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0: cfg_write(REG_WINDOW_LEN, 0);
                    1: cfg_write(REG_WINDOW_LEN, $urandom_range(1, 64));
                    default: cfg_write(REG_WINDOW_LEN, $urandom_range(1, 8));
                endcase
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 6))
                    0: cfg_write(REG_FADE_STEP, 0);
                    1: cfg_write(REG_FADE_STEP, 131071);
                    2: cfg_write(REG_FADE_STEP, 65536);
                    3: cfg_write(REG_FADE_STEP, 1);
                    default: cfg_write(REG_FADE_STEP, $urandom_range(1, 20000));
                endcase
            end
            if ($urandom_range(0, 2) == 0)
                cfg_write(REG_SEED, $urandom);

            seed_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, ITEMS_PER_PHASE - 1) : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (seed_at != 0 && n == seed_at) begin
                    drain_wait();
                    cfg_write(REG_SEED, $urandom);
                end
                sender_gap();
                f.left_in    = rand_sample();
                f.right_in   = rand_sample();
                f.last_frame = $urandom_range(0, 1);
                send_frame(f, 1'b0, '0);
            end
        end

        drain_wait();
        if (pending_frames.size() != 0) begin
            $error("%0d result transactions never arrived", pending_frames.size());
            error_count++;
        end
        if (error_count == 0)
            $display("random_stereo_gate test passed");
        else
            $display("random_stereo_gate test failed");
        $finish;
    end

endmodule

/* random_stereo_gate.f */
design/rsg_pkg.sv
design/rsg_ctrl.sv
design/rsg_dp.sv
design/random_stereo_gate.sv
sim/testbench.sv
